[rtl/sars_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and helpers of the switching-aware ready selector
// no dependencies

package sars_pkg;

    localparam int NODE_W  = 16;
    localparam int OP_W    = 16;
    localparam int IMM_W   = 64;
    localparam int WT_W    = 8;
    localparam int PC_W    = 7;
    localparam int SCORE_W = 15;
    localparam int SLICE_W = 16;
    localparam int NCELL   = IMM_W / SLICE_W;

    localparam logic [WT_W-1:0] SAME_OP_RESET = 8'h1E;
    localparam logic [WT_W-1:0] IMM_BIT_RESET = 8'hFE;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_MARK   = 2'd2,
        CMD_UNMARK = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    localparam logic REG_SAME_OP = 1'b0;
    localparam logic REG_IMM_BIT = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [OP_W-1:0]   op;
        logic [IMM_W-1:0]  imm;
    } entry_t;

    // beat handed from cell to cell along the popcount chain
    typedef struct packed {
        logic              valid;
        logic              match;
        logic [NODE_W-1:0] node;
        logic [PC_W-1:0]   acc;
        logic [IMM_W-1:0]  xr;
    } carry_t;

    function automatic logic [PC_W-1:0] slice_popcount(input logic [SLICE_W-1:0] v);
        logic [PC_W-1:0] n;
        n = '0;
        for (int k = 0; k < SLICE_W; k++)
        begin
            n = n + PC_W'(v[k]);
        end
        return n;
    endfunction

endpackage

[rtl/switching_aware_ready_select.sv]
`timescale 1ns / 1ps
// top level of the switching-aware ready selector
// depends on sars_pkg, sars_ram and sars_cell

// Keeps a ready table and a stack of scheduled instructions, both in ram.
// One result beat follows every command beat, and one command is in work at
// a time. Push and mark go from decode straight to the result. A pop
// with an empty stack takes the last ready entry. A pop with a non-empty
// stack reads the top of the stack, then streams every ready entry through
// a chain of popcount cells (one entry per cycle, one ram read port) and
// scores it. An unmark streams the stack the same way to find the first
// matching node. The removed entry is filled with the last one, which is
// read back from the ram.
module switching_aware_ready_select
    import sars_pkg::*;
#(
    parameter int READY_DEPTH = 64,
    parameter int SCHED_DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // command channel
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [1:0]               cmd,
    input  logic [NODE_W-1:0]        node_id,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [IMM_W-1:0]  imm_value,
    input  logic                     several_imm,
    // result channel
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [NODE_W-1:0]        chosen_node,
    output logic [1:0]               status,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int RA = $clog2(READY_DEPTH);
    localparam int SA = $clog2(SCHED_DEPTH);
    localparam int IW = (RA > SA) ? RA : SA;
    localparam int CW = IW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TOP,
        S_TOPW,
        S_SCAN,
        S_RD_LAST,
        S_WR,
        S_RESP
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [WT_W-1:0] same_op_reg;
    logic [WT_W-1:0] imm_bit_reg;

    // captured command beat
    cmd_t              cmd_reg;
    logic [NODE_W-1:0] node_reg;
    logic [OP_W-1:0]   op_reg;
    logic [IMM_W-1:0]  imm_reg;

    // table and stack fill
    logic [RA:0] ready_count_reg;
    logic [SA:0] sched_count_reg;

    // previous instruction (top of stack)
    logic [OP_W-1:0]  prev_op_reg;
    logic [IMM_W-1:0] prev_imm_reg;

    // scan control
    logic [CW-1:0]     scan_idx_reg;
    logic              rd_v_reg;
    logic [IW-1:0]     res_idx_reg;
    logic              have_best_reg;
    logic signed [SCORE_W-1:0] best_score_reg;
    logic [NODE_W-1:0] best_node_reg;
    logic [IW-1:0]     best_idx_reg;
    logic              use_last_reg;

    // result registers
    logic              res_valid_reg;
    logic [NODE_W-1:0] chosen_reg;
    status_t           status_reg;

    // ram ports
    logic          rdy_we, sch_we;
    logic [RA-1:0] rdy_waddr, rdy_raddr;
    logic [SA-1:0] sch_waddr, sch_raddr;
    entry_t        rdy_wdata, sch_wdata, rdy_rdata, sch_rdata;

    // -------------------------------------------------------------------
    // configuration port: weights at 0x0 and 0x4
    // -------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            same_op_reg <= SAME_OP_RESET;
            imm_bit_reg <= IMM_BIT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_SAME_OP)
            begin
                same_op_reg <= pwdata[WT_W-1:0];
            end
            else
            begin
                imm_bit_reg <= pwdata[WT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SAME_OP) ? {24'd0, same_op_reg} : {24'd0, imm_bit_reg};

    // -------------------------------------------------------------------
    // derived control
    // -------------------------------------------------------------------
    logic          ready_full, sched_full;
    logic [CW-1:0] scan_len;
    logic          is_pop;
    logic [RA-1:0] ready_last;
    logic [SA-1:0] sched_last;

    assign ready_full = (ready_count_reg >= (RA+1)'(READY_DEPTH));
    assign sched_full = (sched_count_reg >= (SA+1)'(SCHED_DEPTH));
    assign is_pop     = (cmd_reg == CMD_POP);
    assign scan_len   = is_pop ? CW'(ready_count_reg) : CW'(sched_count_reg);
    assign ready_last = RA'(ready_count_reg - 1'b1);
    assign sched_last = SA'(sched_count_reg - 1'b1);

    // -------------------------------------------------------------------
    // popcount chain: one entry enters per cycle, scored at the far end
    // -------------------------------------------------------------------
    carry_t chain [NCELL+1];
    entry_t scan_entry;
    logic   chain_busy;

    assign scan_entry = is_pop ? rdy_rdata : sch_rdata;

    assign chain[0] = '{valid: rd_v_reg,
                        match: (scan_entry.op == prev_op_reg),
                        node: scan_entry.node,
                        acc: PC_W'(0),
                        xr: scan_entry.imm ^ prev_imm_reg};

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        sars_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .cin  (chain[g]),
            .cout (chain[g+1])
        );
    end

    always_comb
    begin
        chain_busy = 1'b0;
        for (int k = 0; k <= NCELL; k++)
        begin
            chain_busy = chain_busy | chain[k].valid;
        end
    end

    carry_t tail;
    logic signed [SCORE_W-1:0] w_same, w_bit, pc_s, score;
    logic better, hit;

    assign tail   = chain[NCELL];
    assign w_same = tail.match ? SCORE_W'($signed(same_op_reg)) : '0;
    assign w_bit  = SCORE_W'($signed(imm_bit_reg));
    assign pc_s   = $signed(SCORE_W'(tail.acc));
    assign score  = w_same + w_bit * pc_s;
    // strict order: on a score tie the lower node id wins
    assign better = !have_best_reg || (score > best_score_reg)
                    || ((score == best_score_reg) && (tail.node < best_node_reg));
    assign hit    = !have_best_reg && (tail.node == node_reg);

    logic scan_done;
    assign scan_done = (scan_idx_reg == scan_len) && !chain_busy;

    // -------------------------------------------------------------------
    // ram address and write selection
    // -------------------------------------------------------------------
    always_comb
    begin
        rdy_raddr = scan_idx_reg[RA-1:0];
        sch_raddr = scan_idx_reg[SA-1:0];
        rdy_we    = 1'b0;
        sch_we    = 1'b0;
        rdy_waddr = ready_count_reg[RA-1:0];
        sch_waddr = sched_count_reg[SA-1:0];
        rdy_wdata = '{node: node_reg, op: op_reg, imm: imm_reg};
        sch_wdata = '{node: node_reg, op: op_reg, imm: imm_reg};
        case (state_reg)
            S_DECODE:
            begin
                rdy_we = (cmd_reg == CMD_PUSH) && !ready_full;
                sch_we = (cmd_reg == CMD_MARK) && !sched_full;
            end
            S_TOP:
            begin
                sch_raddr = sched_last;
            end
            S_RD_LAST:
            begin
                rdy_raddr = ready_last;
                sch_raddr = sched_last;
            end
            S_WR:
            begin
                rdy_we    = is_pop;
                sch_we    = !is_pop;
                rdy_waddr = use_last_reg ? ready_last : best_idx_reg[RA-1:0];
                sch_waddr = best_idx_reg[SA-1:0];
                rdy_wdata = rdy_rdata;
                sch_wdata = sch_rdata;
            end
            default:
            begin
            end
        endcase
    end

    sars_ram #(.WIDTH($bits(entry_t)), .DEPTH(READY_DEPTH)) u_ready_ram (
        .clk  (clk),
        .we   (rdy_we),
        .waddr(rdy_waddr),
        .wdata(rdy_wdata),
        .raddr(rdy_raddr),
        .rdata(rdy_rdata)
    );

    sars_ram #(.WIDTH($bits(entry_t)), .DEPTH(SCHED_DEPTH)) u_sched_ram (
        .clk  (clk),
        .we   (sch_we),
        .waddr(sch_waddr),
        .wdata(sch_wdata),
        .raddr(sch_raddr),
        .rdata(sch_rdata)
    );

    // -------------------------------------------------------------------
    // sequencer
    // -------------------------------------------------------------------
    assign item_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ready_count_reg <= '0;
            sched_count_reg <= '0;
            res_valid_reg   <= 1'b0;
            rd_v_reg        <= 1'b0;
            scan_idx_reg    <= '0;
            have_best_reg   <= 1'b0;
        end
        else
        begin
            // one ram read issued per scan cycle until the list is exhausted
            rd_v_reg <= (state_reg == S_SCAN) && (scan_idx_reg != scan_len);
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    scan_idx_reg  <= '0;
                    have_best_reg <= 1'b0;
                    case (cmd_reg)
                        CMD_PUSH:
                        begin
                            state_reg <= S_RESP;
                            if (!ready_full)
                            begin
                                ready_count_reg <= ready_count_reg + 1'b1;
                            end
                        end
                        CMD_MARK:
                        begin
                            state_reg <= S_RESP;
                            if (!sched_full)
                            begin
                                sched_count_reg <= sched_count_reg + 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            if (ready_count_reg != '0)
                            begin
                                state_reg <= (sched_count_reg == '0) ? S_RD_LAST : S_TOP;
                            end
                            else
                            begin
                                state_reg <= S_RESP;
                            end
                        end
                        default:
                        begin
                            state_reg <= (sched_count_reg != '0) ? S_SCAN : S_RESP;
                        end
                    endcase
                end
                S_TOP:
                begin
                    state_reg <= S_TOPW;
                end
                S_TOPW:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_idx_reg != scan_len)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    if (tail.valid && (is_pop ? better : hit))
                    begin
                        have_best_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        state_reg <= (is_pop || have_best_reg) ? S_RD_LAST : S_RESP;
                    end
                end
                S_RD_LAST:
                begin
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    state_reg <= S_RESP;
                    if (is_pop)
                    begin
                        ready_count_reg <= ready_count_reg - 1'b1;
                    end
                    else
                    begin
                        sched_count_reg <= sched_count_reg - 1'b1;
                    end
                end
                S_RESP:
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_reg <= 1'b1;
                    end
                    else if (res_ready)
                    begin
                        res_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload side of the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg  <= cmd_t'(cmd);
                node_reg <= node_id;
                op_reg   <= opcode;
                imm_reg  <= several_imm ? '0 : imm_value;
            end
            S_DECODE:
            begin
                chosen_reg   <= '0;
                res_idx_reg  <= '0;
                use_last_reg <= (sched_count_reg == '0);
                case (cmd_reg)
                    CMD_PUSH:   status_reg <= ready_full ? ST_FULL : ST_OK;
                    CMD_MARK:   status_reg <= sched_full ? ST_FULL : ST_OK;
                    CMD_POP:    status_reg <= (ready_count_reg == '0) ? ST_EMPTY : ST_OK;
                    default:    status_reg <= (sched_count_reg == '0) ? ST_NOT_FOUND : ST_OK;
                endcase
            end
            S_TOPW:
            begin
                prev_op_reg  <= sch_rdata.op;
                prev_imm_reg <= sch_rdata.imm;
            end
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    res_idx_reg <= res_idx_reg + 1'b1;
                    if (is_pop ? better : hit)
                    begin
                        best_score_reg <= score;
                        best_node_reg  <= tail.node;
                        best_idx_reg   <= res_idx_reg;
                    end
                end
                if (scan_done && !is_pop && !have_best_reg)
                begin
                    status_reg <= ST_NOT_FOUND;
                end
            end
            S_WR:
            begin
                if (is_pop)
                begin
                    chosen_reg <= use_last_reg ? rdy_rdata.node : best_node_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid   = res_valid_reg;
    assign chosen_node = chosen_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    // one command in work at a time: no acceptance while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) !(res_valid && item_ready))
        else $error("result pending while accepting a command");

    // fill levels never pass the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (ready_count_reg <= (RA+1)'(READY_DEPTH)) && (sched_count_reg <= (SA+1)'(SCHED_DEPTH)))
        else $error("fill level beyond depth");

    // a failed command never names a node
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status != ST_OK)) |-> (chosen_node == '0))
        else $error("node reported on a failed command");

    // a pop that succeeds shrinks the ready table by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && is_pop) |=> (ready_count_reg == $past(ready_count_reg) - 1'b1))
        else $error("ready table did not shrink on pop");
`endif

endmodule

[rtl/sars_ram.sv]
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies

module sars_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sars_cell.sv]
`timescale 1ns / 1ps
// one popcount cell: adds the bit count of the low slice, shifts the rest on
// depends on sars_pkg

module sars_cell
    import sars_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  carry_t cin,
    output carry_t cout
);

    logic              valid_reg;
    logic              match_reg;
    logic [NODE_W-1:0] node_reg;
    logic [PC_W-1:0]   acc_reg;
    logic [IMM_W-1:0]  xr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= cin.match;
        node_reg  <= cin.node;
        acc_reg   <= cin.acc + slice_popcount(cin.xr[SLICE_W-1:0]);
        xr_reg    <= cin.xr >> SLICE_W;
    end

    assign cout = '{valid: valid_reg, match: match_reg, node: node_reg,
                    acc: acc_reg, xr: xr_reg};

endmodule

[test/switching_aware_ready_select_test.sv]
`timescale 1ns / 1ps
// self-checking bench for the switching-aware ready selector
// depends on sars_pkg and the switching_aware_ready_select rtl

module switching_aware_ready_select_test;
    import sars_pkg::*;

    localparam int READY_DEPTH = 64;
    localparam int SCHED_DEPTH = 256;
    localparam int N_RANDOM    = 1400;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 400;
    localparam logic [2:0] ADDR_SAME_OP = 3'd0;
    localparam logic [2:0] ADDR_IMM_BIT = 3'd4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic [1:0] cmd = CMD_PUSH;
    logic [NODE_W-1:0] node_id = '0;
    logic [OP_W-1:0] opcode = '0;
    logic signed [IMM_W-1:0] imm_value = '0;
    logic several_imm = 1'b0;
    logic res_valid;
    logic res_ready = 1'b0;
    logic [NODE_W-1:0] chosen_node;
    logic [1:0] status;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    always #5 clk = ~clk;

    switching_aware_ready_select #(
        .READY_DEPTH(READY_DEPTH),
        .SCHED_DEPTH(SCHED_DEPTH)
    ) uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .cmd(cmd), .node_id(node_id), .opcode(opcode),
        .imm_value(imm_value), .several_imm(several_imm),
        .res_valid(res_valid), .res_ready(res_ready),
        .chosen_node(chosen_node), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // one beat of the result channel as we expect to see it
    typedef struct {
        logic [NODE_W-1:0] node;
        status_t           st;
    } outcome_t;

    // a row of the directed table; has_fixed marks rows whose result is typed in
    typedef struct {
        cmd_t              c;
        logic [NODE_W-1:0] node;
        logic [OP_W-1:0]   op;
        logic [IMM_W-1:0]  imm;
        logic              several;
        logic              has_fixed;
        logic [NODE_W-1:0] fixed_node;
        status_t           fixed_st;
    } stim_row_t;

    // private mirror of the block state
    entry_t ready_tab[READY_DEPTH];
    int     ready_len;
    entry_t sched_stk[SCHED_DEPTH];
    int     sched_len;
    logic signed [WT_W-1:0] w_same_op;
    logic signed [WT_W-1:0] w_imm_bit;

    outcome_t pending[$];
    int errors = 0;
    int idle_cycles = 0;

    // typed-in expectation of the directed row being sent
    logic              row_fixed = 1'b0;
    int                row_idx = 0;
    logic [NODE_W-1:0] row_node = '0;
    status_t           row_st = ST_OK;

    function automatic int bits_set(input logic [IMM_W-1:0] v);
        int n;
        n = 0;
        for (int k = 0; k < IMM_W; k++)
        begin
            n += v[k];
        end
        return n;
    endfunction

    // applies one command to the mirror and returns the beat it should cause
    function automatic outcome_t apply_command(input cmd_t c, input logic [NODE_W-1:0] nd,
                                               input logic [OP_W-1:0] op,
                                               input logic [IMM_W-1:0] imm_in,
                                               input logic several);
        outcome_t o;
        entry_t e;
        entry_t prev;
        int best;
        int best_score;
        int s;
        int hit;
        o.node = '0;
        o.st = ST_OK;
        e.node = nd;
        e.op = op;
        e.imm = several ? '0 : imm_in;
        case (c)
            CMD_PUSH:
            begin
                if (ready_len >= READY_DEPTH)
                    o.st = ST_FULL;
                else
                begin
                    ready_tab[ready_len] = e;
                    ready_len++;
                end
            end
            CMD_POP:
            begin
                if (ready_len == 0)
                    o.st = ST_EMPTY;
                else
                begin
                    best = ready_len - 1;
                    if (sched_len > 0)
                    begin
                        prev = sched_stk[sched_len - 1];
                        best = 0;
                        best_score = 0;
                        for (int i = 0; i < ready_len; i++)
                        begin
                            s = (ready_tab[i].op == prev.op) ? int'(w_same_op) : 0;
                            s += int'(w_imm_bit) * bits_set(ready_tab[i].imm ^ prev.imm);
                            if (i == 0 || s > best_score ||
                                (s == best_score && ready_tab[i].node < ready_tab[best].node))
                            begin
                                best_score = s;
                                best = i;
                            end
                        end
                    end
                    o.node = ready_tab[best].node;
                    ready_tab[best] = ready_tab[ready_len - 1];
                    ready_len--;
                end
            end
            CMD_MARK:
            begin
                if (sched_len >= SCHED_DEPTH)
                    o.st = ST_FULL;
                else
                begin
                    sched_stk[sched_len] = e;
                    sched_len++;
                end
            end
            default:
            begin
                hit = -1;
                for (int i = 0; i < sched_len && hit < 0; i++)
                begin
                    if (sched_stk[i].node == nd)
                        hit = i;
                end
                if (hit < 0)
                    o.st = ST_NOT_FOUND;
                else
                begin
                    sched_stk[hit] = sched_stk[sched_len - 1];
                    sched_len--;
                end
            end
        endcase
        return o;
    endfunction

    // prediction happens at the edge where the command beat is taken;
    // typed-in rows must also agree with the mirror
    always @(posedge clk)
    begin
        outcome_t o;
        if (rst_n && item_valid && item_ready)
        begin
            o = apply_command(cmd_t'(cmd), node_id, opcode, imm_value, several_imm);
            pending.insert(pending.size(), o);
            if (row_fixed && (o.node !== row_node || o.st !== row_st))
            begin
                $display("%0t: row %0d expected node %0d status %0d actual %0d %0d",
                         $time, row_idx, row_node, row_st, o.node, o.st);
                errors++;
            end
        end
    end

    // result checker: every beat against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending.size() == 0)
            begin
                $display("%0t: result beat with nothing expected (node %0d status %0d)",
                         $time, chosen_node, status);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (chosen_node !== want.node)
                begin
                    $display("%0t: chosen_node expected %0d actual %0d",
                             $time, want.node, chosen_node);
                    errors++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    errors++;
                end
            end
        end
    end

    // receiver stalls on its own pattern: phases of free flow, of light and of heavy back-pressure
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: res_ready <= 1'b1;
            1: res_ready <= ($urandom_range(0, 3) != 0);
            default: res_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one command beat, honouring the sender burst/gap pattern;
    // valid drops only when a gap follows
    int burst_left = 0;
    task automatic send_beat(input cmd_t c, input logic [NODE_W-1:0] nd,
                             input logic [OP_W-1:0] op, input logic [IMM_W-1:0] imm,
                             input logic several);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        item_valid <= 1'b1;
        cmd <= c;
        node_id <= nd;
        opcode <= op;
        imm_value <= imm;
        several_imm <= several;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {{24{value[7]}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SAME_OP)
            w_same_op = value;
        else
            w_imm_bit = value;
        @(posedge clk);
    endtask

    // let the block fall idle before touching its registers
    task automatic drain;
        item_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // random immediate: mostly small hamming spreads so scores actually tie and differ
    function automatic logic [IMM_W-1:0] rand_imm();
        logic [IMM_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = {$urandom, $urandom};
            1: v = IMM_W'($urandom_range(0, 7));
            2: v = ~IMM_W'($urandom_range(0, 7));
            default: v = IMM_W'(1) << $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    stim_row_t directed[$];

    task automatic add_row(input cmd_t c, input logic [NODE_W-1:0] nd,
                           input logic [OP_W-1:0] op, input logic [IMM_W-1:0] imm,
                           input logic several, input logic fixed,
                           input logic [NODE_W-1:0] fnode, input status_t fst);
        stim_row_t r;
        r.c = c;
        r.node = nd;
        r.op = op;
        r.imm = imm;
        r.several = several;
        r.has_fixed = fixed;
        r.fixed_node = fnode;
        r.fixed_st = fst;
        directed.insert(directed.size(), r);
    endtask

    initial
    begin
        cmd_t c;
        logic [NODE_W-1:0] nd;
        int fill;

        ready_len = 0;
        sched_len = 0;
        w_same_op = SAME_OP_RESET;
        w_imm_bit = IMM_BIT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: empty pop, absent unmark, extremes of every field
        add_row(CMD_POP, 16'd5, 16'd0, '0, 1'b0, 1'b1, 16'd0, ST_EMPTY);
        add_row(CMD_UNMARK, 16'hFFFF, 16'd0, '0, 1'b0, 1'b1, 16'd0, ST_NOT_FOUND);
        add_row(CMD_PUSH, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
                1'b1, 16'd0, ST_OK);
        // no scheduled instruction yet: pop takes the last entry
        add_row(CMD_POP, 16'd0, 16'd0, '0, 1'b0, 1'b1, 16'hFFFF, ST_OK);
        add_row(CMD_PUSH, 16'd0, 16'd0, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 16'd0, ST_OK);
        add_row(CMD_PUSH, 16'd7, 16'd3, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 16'd0, ST_OK);
        add_row(CMD_PUSH, 16'd9, 16'd3, 64'd1, 1'b0, 1'b1, 16'd0, ST_OK);
        add_row(CMD_MARK, 16'd100, 16'd3, 64'd0, 1'b0, 1'b1, 16'd0, ST_OK);
        add_row(CMD_POP, 16'd0, 16'd0, '0, 1'b0, 1'b0, 16'd0, ST_OK);
        add_row(CMD_MARK, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                1'b1, 16'd0, ST_OK);
        add_row(CMD_POP, 16'd0, 16'd0, '0, 1'b0, 1'b0, 16'd0, ST_OK);
        add_row(CMD_UNMARK, 16'd100, 16'd0, '0, 1'b0, 1'b1, 16'd0, ST_OK);
        add_row(CMD_UNMARK, 16'd100, 16'd0, '0, 1'b0, 1'b1, 16'd0, ST_NOT_FOUND);
        add_row(CMD_POP, 16'd0, 16'd0, '0, 1'b0, 1'b0, 16'd0, ST_OK);
        add_row(CMD_POP, 16'd0, 16'd0, '0, 1'b0, 1'b1, 16'd0, ST_EMPTY);
        add_row(CMD_UNMARK, 16'hFFFF, 16'd0, '0, 1'b0, 1'b1, 16'd0, ST_OK);

        foreach (directed[i])
        begin
            // takes effect after the previous row's accepting edge
            row_fixed <= directed[i].has_fixed;
            row_idx <= i;
            row_node <= directed[i].fixed_node;
            row_st <= directed[i].fixed_st;
            send_beat(directed[i].c, directed[i].node, directed[i].op, directed[i].imm,
                      directed[i].several);
        end

        // full table and full stack, reached under the reset weights
        drain;
        row_fixed <= 1'b0;
        for (fill = 0; fill <= READY_DEPTH; fill++)
            send_beat(CMD_PUSH, NODE_W'($urandom), OP_W'($urandom_range(0, 3)), rand_imm(),
                      1'($urandom_range(0, 1)));
        for (fill = 0; fill <= SCHED_DEPTH; fill++)
            send_beat(CMD_MARK, NODE_W'(fill), OP_W'($urandom_range(0, 3)), rand_imm(),
                      1'($urandom_range(0, 1)));

        // random phases, each under its own weights, extremes included
        for (int phase = 0; phase < 7; phase++)
        begin
            drain;
            case (phase)
                0: begin write_reg(ADDR_SAME_OP, 8'h7F); write_reg(ADDR_IMM_BIT, 8'h80); end
                1: begin write_reg(ADDR_SAME_OP, 8'h80); write_reg(ADDR_IMM_BIT, 8'h7F); end
                2: begin write_reg(ADDR_SAME_OP, 8'h00); write_reg(ADDR_IMM_BIT, 8'h00); end
                3: begin write_reg(ADDR_SAME_OP, 8'h1E); write_reg(ADDR_IMM_BIT, 8'hFE); end
                default:
                begin
                    write_reg(ADDR_SAME_OP, 8'($urandom));
                    write_reg(ADDR_IMM_BIT, 8'($urandom));
                end
            endcase
            for (int k = 0; k < N_RANDOM / 7; k++)
            begin
                // weight towards balanced push/pop with marks so pops score entries
                case ($urandom_range(0, 9))
                    0, 1, 2: c = CMD_PUSH;
                    3, 4, 5: c = CMD_POP;
                    6, 7: c = CMD_MARK;
                    default: c = CMD_UNMARK;
                endcase
                if (c == CMD_UNMARK && sched_len > 0 && $urandom_range(0, 3) != 0)
                    nd = sched_stk[$urandom_range(0, sched_len - 1)].node;
                else if ($urandom_range(0, 7) == 0)
                    nd = NODE_W'($urandom);
                else
                    nd = NODE_W'($urandom_range(0, 31));
                send_beat(c, nd, ($urandom_range(0, 7) == 0) ? OP_W'($urandom)
                                                             : OP_W'($urandom_range(0, 3)),
                          rand_imm(), ($urandom_range(0, 5) == 0));
            end
        end

        drain;
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
